// ===== rtl/mlpq_pkg.sv =====
package mlpq_pkg;

    // default sizing
    localparam int LEVELS_DEF      = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_WIDTH      = 32;

    // configuration register
    localparam logic [3:0] NUM_LEVELS_RESET = 4'd8;
    localparam logic       REG_NUM_LEVELS   = 1'b0;

    // command codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_SPARE  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPRI = 2'd3
    } status_t;

    // decoded command kind
    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    // input word
    typedef struct packed {
        logic [1:0]            op;
        logic [2:0]            priority_req;
        logic [TASK_WIDTH-1:0] task_payload;
    } cmd_t;

    // result word
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] head_payload;
        logic [2:0]  head_priority;
        logic        all_empty;
        logic [7:0]  total_count;
        logic [4:0]  level_count;
    } result_t;

    // classified command held between front and back
    typedef struct packed {
        kind_t                 kind;
        logic                  in_range;
        logic [2:0]            pri;
        logic [TASK_WIDTH-1:0] payload;
    } entry_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } qhead_t;

endpackage

// ===== rtl/mlpq_ram.sv =====
module mlpq_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mlpq_front.sv =====
module mlpq_front
    import mlpq_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  cmd_t                        cmd,
    input  logic [$clog2(LEVELS+1)-1:0] nlev,
    output logic                        busy,
    output qhead_t                      qhead,
    input  logic                        qpop
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    entry_t     slot_reg [2];
    entry_t     cls;
    logic       push;

    // classify the incoming word
    always_comb
    begin
        cls.pri      = cmd.priority_req;
        cls.payload  = cmd.task_payload;
        cls.in_range = (32'(cmd.priority_req) < 32'(nlev));
        case (cmd.op)
            OP_ADD:    cls.kind = KIND_ADD;
            OP_REMOVE: cls.kind = KIND_REMOVE;
            default:   cls.kind = KIND_QUERY;
        endcase
    end

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;

    // two-entry command queue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !qpop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && qpop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (qpop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    assign qhead.valid = (count_reg != 2'd0);
    assign qhead.entry = slot_reg[rd_ptr_reg];

endmodule

// ===== rtl/mlpq_back.sv =====
module mlpq_back
    import mlpq_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_clear,
    input  logic [$clog2(LEVELS+1)-1:0] nlev,
    input  qhead_t                      qhead,
    output logic                        qpop,
    output logic                        done,
    output result_t                     result
);

    localparam int LW = $clog2(LEVELS);
    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = $clog2(LEVELS * QUEUE_DEPTH + 1);
    localparam int AW = $clog2(LEVELS * QUEUE_DEPTH);

    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_LOOK = 3'b010,
        BS_OUT  = 3'b100
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic [SW-1:0] head_reg [LEVELS];
    logic [SW-1:0] tail_reg [LEVELS];
    logic [CW-1:0] fill_reg [LEVELS];
    logic [TW-1:0] total_reg;

    entry_t        cur_reg;
    status_t       status_reg;
    logic [LW-1:0] top_reg;
    logic          empty_reg;
    logic [4:0]    lcount_reg;

    logic [LW-1:0] top;
    logic          found;
    logic [LW-1:0] pri_idx;
    logic [LW-1:0] cur_idx;
    logic          do_add;
    logic          do_remove;
    status_t       status_new;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [TASK_WIDTH-1:0] rdata;

    function automatic logic [AW-1:0] slot_addr(logic [LW-1:0] lv, logic [SW-1:0] slot);
        return AW'(int'(lv) * QUEUE_DEPTH + int'(slot));
    endfunction

    function automatic logic [SW-1:0] next_slot(logic [SW-1:0] s);
        return (s == SW'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // highest non-empty level in use
    always_comb
    begin
        top   = '0;
        found = 1'b0;
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            if ((lv < int'(nlev)) && (fill_reg[lv] != '0))
            begin
                top   = LW'(lv);
                found = 1'b1;
            end
        end
    end

    assign pri_idx = LW'(qhead.entry.pri);
    assign cur_idx = LW'(cur_reg.pri);

    // execute decision for the word at the queue head
    always_comb
    begin
        do_add     = 1'b0;
        do_remove  = 1'b0;
        status_new = ST_OK;
        case (qhead.entry.kind)
            KIND_ADD:
            begin
                if (!qhead.entry.in_range)
                begin
                    status_new = ST_BADPRI;
                end
                else if (fill_reg[pri_idx] == CW'(QUEUE_DEPTH))
                begin
                    status_new = ST_FULL;
                end
                else
                begin
                    do_add = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (!found)
                begin
                    status_new = ST_EMPTY;
                end
                else
                begin
                    do_remove = 1'b1;
                end
            end
            default:
            begin
                status_new = ST_OK;
            end
        endcase
    end

    assign qpop  = (state_reg == BS_IDLE) && qhead.valid;
    assign waddr = slot_addr(pri_idx, tail_reg[pri_idx]);
    assign raddr = slot_addr(top, head_reg[top]);

    // task storage
    mlpq_ram #(
        .WIDTH (TASK_WIDTH),
        .DEPTH (LEVELS * QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (qpop && do_add),
        .waddr (waddr),
        .wdata (qhead.entry.payload),
        .re    (state_reg == BS_LOOK),
        .raddr (raddr),
        .rdata (rdata)
    );

    // sequencer: execute, read head task, deliver
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE: if (qhead.valid) state_next = BS_LOOK;
            BS_LOOK: state_next = BS_OUT;
            BS_OUT:  state_next = BS_IDLE;
            default: state_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // per-level pointers and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int lv = 0; lv < LEVELS; lv++)
            begin
                head_reg[lv] <= '0;
                tail_reg[lv] <= '0;
                fill_reg[lv] <= '0;
            end
            total_reg <= '0;
        end
        else if (cfg_clear)
        begin
            for (int lv = 0; lv < LEVELS; lv++)
            begin
                head_reg[lv] <= '0;
                tail_reg[lv] <= '0;
                fill_reg[lv] <= '0;
            end
            total_reg <= '0;
        end
        else if (qpop && do_add)
        begin
            tail_reg[pri_idx] <= next_slot(tail_reg[pri_idx]);
            fill_reg[pri_idx] <= fill_reg[pri_idx] + 1'b1;
            total_reg         <= total_reg + 1'b1;
        end
        else if (qpop && do_remove)
        begin
            head_reg[top] <= next_slot(head_reg[top]);
            fill_reg[top] <= fill_reg[top] - 1'b1;
            total_reg     <= total_reg - 1'b1;
        end
    end

    // result fields
    always_ff @(posedge clk)
    begin
        if (qpop)
        begin
            cur_reg    <= qhead.entry;
            status_reg <= status_new;
        end
        if (state_reg == BS_LOOK)
        begin
            top_reg    <= top;
            empty_reg  <= !found;
            lcount_reg <= cur_reg.in_range ? 5'(fill_reg[cur_idx]) : 5'd0;
        end
    end

    assign done                 = (state_reg == BS_OUT);
    assign result.status        = status_reg;
    assign result.head_payload  = empty_reg ? '0 : rdata[31:0];
    assign result.head_priority = empty_reg ? 3'd0 : 3'(top_reg);
    assign result.all_empty     = empty_reg;
    assign result.total_count   = 8'(total_reg);
    assign result.level_count   = lcount_reg;

endmodule

// ===== rtl/multilevel_priority_queue_unit.sv =====
// Strict-priority task queue with one FIFO of QUEUE_DEPTH tasks per level; the
// highest level number is served first. A command is taken when start is high
// and busy is low, and goes into a two-deep command queue. The execution
// sequencer handles one command at a time in its idle, look and out states
// (update pointers and write the task memory, read the new head task,
// deliver), taking a new command only in idle once the last one is delivered;
// done pulses for one cycle in the out state. The receiver cannot stall:
// the result word is valid only in the cycle done is high. Writing num_levels
// empties every level in the following cycle; write it only while idle.
module multilevel_priority_queue_unit
    import mlpq_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    output logic        busy,
    output logic        done,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NLW = $clog2(LEVELS + 1);

    logic [3:0]     num_levels_reg;
    logic [NLW-1:0] nlev;
    logic           cfg_wr;
    qhead_t         qhead;
    logic           qpop;

    // register write decode; byte offset bits are ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_LEVELS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_levels_reg <= NUM_LEVELS_RESET;
        end
        else if (cfg_wr)
        begin
            num_levels_reg <= pwdata[3:0];
        end
    end

    // register read
    assign prdata = (paddr[2] == REG_NUM_LEVELS) ? {28'd0, num_levels_reg} : 32'd0;

    // levels actually in use
    assign nlev = (32'(num_levels_reg) < 32'(LEVELS)) ? NLW'(num_levels_reg) : NLW'(LEVELS);

    mlpq_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .nlev  (nlev),
        .busy  (busy),
        .qhead (qhead),
        .qpop  (qpop)
    );

    mlpq_back #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_clear (cfg_wr),
        .nlev      (nlev),
        .qhead     (qhead),
        .qpop      (qpop),
        .done      (done),
        .result    (result)
    );

endmodule

// ===== rtl/mlpq_checker.sv =====
module mlpq_checker
    import mlpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // results never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done high in consecutive cycles");

    // an empty queue reports a zero head and zero total
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.all_empty) |->
            (result.head_payload == 32'd0 && result.head_priority == 3'd0 &&
             result.total_count == 8'd0))
        else $error("empty result carries a head task or a count");

    // a failed remove means everything is empty
    a_remove_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |-> result.all_empty)
        else $error("remove reported empty while tasks are held");

    // a dropped add leaves its level full
    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |->
            (result.level_count == 5'(QUEUE_DEPTH) && !result.all_empty))
        else $error("full status on a level that is not full");

    // busy rises only after a word has been taken
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose with no word taken");

endmodule

bind multilevel_priority_queue_unit mlpq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mlpq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
